// ===== hw/rtl/dpol_pkg.sv =====
package dpol_pkg;

    localparam int CODE_W   = 32;
    localparam int CMD_W    = 2;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic                     list_select;
        logic [POS_W-1:0]         position;
        logic signed [CODE_W-1:0] item_code;
    } in_word_t;

    typedef struct packed {
        logic signed [CODE_W-1:0] result_code;
        logic [STATUS_W-1:0]      status;
        logic [COUNT_W-1:0]       count_a;
        logic [COUNT_W-1:0]       count_b;
    } out_word_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

endpackage

// ===== hw/rtl/dual_positional_ordered_list_unit.sv =====
// dual positional ordered list unit
//
// keeps two ordered lists, a and b, of up to LIST_DEPTH 32-bit codes each.
// a command word on the s_ channel inserts a code before a 1-based position,
// removes the code at a position, or moves the code at a position of list a
// to the tail of list b. every command word yields exactly one result word on
// the m_ channel: the removed or moved code, a status (ok, empty, full) and
// both list counts after the command.
//
// timing: a command word is taken into the command register, and the lists are
// updated from it in the exec state, when the result word is loaded into the
// output register; m_valid is registered and rises with that load. the unit
// takes a new command only once the update of the previous one is done, set by
// the load and update steps of the controller around the single row of shifting
// cells per list. s_ready drops after each accepted command until its update.
//
// a stalled receiver holds the result word in the output register; the next
// command is still accepted but its update waits until the word is taken.
// reset (aresetn low, synchronous) empties both lists and drops m_valid; list
// cells themselves are not cleared, only the counts.
module dual_positional_ordered_list_unit #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    // command words
    input  logic                s_valid,
    output logic                s_ready,
    input  dpol_pkg::in_word_t  s_data,
    // result words
    output logic                m_valid,
    input  logic                m_ready,
    output dpol_pkg::out_word_t m_data
);

    dpol_pkg::ctl_t ctl;

    // handshake and sequencing
    dpol_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .ctl     (ctl)
    );

    // list cells, counts and the output word register
    dpol_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (ctl),
        .in_data  (s_data),
        .out_data (m_data)
    );

    // one command in flight: no second word is taken right after one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("command word taken while the previous one is updating");

    // a refused command returns no code
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != dpol_pkg::ST_OK) |-> (m_data.result_code == '0))
        else $error("nonzero result code with error status");

    // reset leaves no result word pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // a result word appears only after an update that follows an accepted command
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(ctl.exec))
        else $error("result word without an update");

endmodule

// ===== hw/rtl/dpol_ctrl.sv =====
module dpol_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    output logic          m_valid,
    input  logic          m_ready,
    output dpol_pkg::ctl_t ctl
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   fire;

    // the update may go ahead once the output register is free or being emptied
    assign fire    = (state_reg == S_EXEC) && (!out_valid_reg || m_ready);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    assign ctl.load = s_valid && s_ready;
    assign ctl.exec = fire;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (fire) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== hw/rtl/dpol_datapath.sv =====
module dpol_datapath #(
    parameter int LIST_DEPTH = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  dpol_pkg::ctl_t     ctl,
    input  dpol_pkg::in_word_t in_data,
    output dpol_pkg::out_word_t out_data
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int IW = (CW > dpol_pkg::POS_W) ? CW : dpol_pkg::POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    dpol_pkg::in_word_t  cmd_reg;
    dpol_pkg::out_word_t out_reg;

    logic [dpol_pkg::CODE_W-1:0] a_reg [LIST_DEPTH];
    logic [dpol_pkg::CODE_W-1:0] a_next [LIST_DEPTH];
    logic [dpol_pkg::CODE_W-1:0] b_reg [LIST_DEPTH];
    logic [dpol_pkg::CODE_W-1:0] b_next [LIST_DEPTH];
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;

    logic [dpol_pkg::POS_W-1:0]    idx;
    logic [CW-1:0]                 n_sel, n_rem, ins_pos, rem_pos, a_pos, b_pos;
    logic [dpol_pkg::CODE_W-1:0]   rem_val, a_code, b_code, result;
    logic [dpol_pkg::STATUS_W-1:0] status;
    logic                          ins_a, ins_b, rem_a, rem_b;

    // 1-based position to index, front for 0 and 1
    assign idx   = (cmd_reg.position <= 8'd1) ? '0 : cmd_reg.position - 8'd1;
    assign n_sel = cmd_reg.list_select ? cnt_b_reg : cnt_a_reg;
    assign n_rem = (cmd_reg.cmd == dpol_pkg::CMD_MOVE) ? cnt_a_reg : n_sel;

    // insert clamps to the tail, remove clamps to the last entry
    assign ins_pos = (IW'(idx) > IW'(n_sel)) ? n_sel : CW'(idx);
    assign rem_pos = (IW'(idx) >= IW'(n_rem)) ? n_rem - CW'(1) : CW'(idx);

    assign rem_val = (cmd_reg.cmd == dpol_pkg::CMD_REMOVE && cmd_reg.list_select)
                   ? b_reg[rem_pos[AW-1:0]] : a_reg[rem_pos[AW-1:0]];

    always_comb begin
        ins_a  = 1'b0;
        ins_b  = 1'b0;
        rem_a  = 1'b0;
        rem_b  = 1'b0;
        a_pos  = ins_pos;
        b_pos  = ins_pos;
        a_code = cmd_reg.item_code;
        b_code = cmd_reg.item_code;
        result = '0;
        status = dpol_pkg::ST_OK;
        case (cmd_reg.cmd)
            dpol_pkg::CMD_INSERT: begin
                if (n_sel == DEPTH_C) begin
                    status = dpol_pkg::ST_FULL;
                end else begin
                    ins_a = !cmd_reg.list_select;
                    ins_b = cmd_reg.list_select;
                end
            end
            dpol_pkg::CMD_REMOVE: begin
                if (n_sel == '0) begin
                    status = dpol_pkg::ST_EMPTY;
                end else begin
                    rem_a  = !cmd_reg.list_select;
                    rem_b  = cmd_reg.list_select;
                    a_pos  = rem_pos;
                    b_pos  = rem_pos;
                    result = rem_val;
                end
            end
            dpol_pkg::CMD_MOVE: begin
                if (cnt_a_reg == '0) begin
                    status = dpol_pkg::ST_EMPTY;
                end else if (cnt_b_reg == DEPTH_C) begin
                    status = dpol_pkg::ST_FULL;
                end else begin
                    rem_a  = 1'b1;
                    ins_b  = 1'b1;
                    a_pos  = rem_pos;
                    b_pos  = cnt_b_reg;
                    b_code = rem_val;
                    result = rem_val;
                end
            end
            default: begin
            end
        endcase
    end

    // each cell takes its own value, its lower neighbor, its upper neighbor or the new code
    always_comb begin
        for (int i = 0; i < LIST_DEPTH; i++) begin
            a_next[i] = a_reg[i];
            b_next[i] = b_reg[i];
            if (ins_a) begin
                if (CW'(i) > a_pos) begin
                    a_next[i] = a_reg[(i == 0) ? 0 : i - 1];
                end else if (CW'(i) == a_pos) begin
                    a_next[i] = a_code;
                end
            end else if (rem_a && CW'(i) >= a_pos) begin
                a_next[i] = a_reg[(i == LIST_DEPTH - 1) ? i : i + 1];
            end
            if (ins_b) begin
                if (CW'(i) > b_pos) begin
                    b_next[i] = b_reg[(i == 0) ? 0 : i - 1];
                end else if (CW'(i) == b_pos) begin
                    b_next[i] = b_code;
                end
            end else if (rem_b && CW'(i) >= b_pos) begin
                b_next[i] = b_reg[(i == LIST_DEPTH - 1) ? i : i + 1];
            end
        end
    end

    always_comb begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        if (ins_a) begin
            cnt_a_next = cnt_a_reg + CW'(1);
        end else if (rem_a) begin
            cnt_a_next = cnt_a_reg - CW'(1);
        end
        if (ins_b) begin
            cnt_b_next = cnt_b_reg + CW'(1);
        end else if (rem_b) begin
            cnt_b_next = cnt_b_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
        end else if (ctl.exec) begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_data;
        end
        if (ctl.exec) begin
            a_reg                <= a_next;
            b_reg                <= b_next;
            out_reg.result_code  <= result;
            out_reg.status       <= status;
            out_reg.count_a      <= dpol_pkg::COUNT_W'(cnt_a_next);
            out_reg.count_b      <= dpol_pkg::COUNT_W'(cnt_b_next);
        end
    end

    assign out_data = out_reg;

endmodule

// ===== dv/dpol_tb_pkg.sv =====
`timescale 1ns / 100ps

package dpol_tb_pkg;

    import dpol_pkg::*;

    localparam int LIST_DEPTH = 16;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic             LIST_A     = 1'b0;
    localparam logic             LIST_B     = 1'b1;

    class list_scoreboard;

        logic signed [CODE_W-1:0] lists [2][LIST_DEPTH];
        int unsigned              counts [2];
        out_word_t                result_q [$];
        int unsigned              failures;

        function new();
            counts[0] = 0;
            counts[1] = 0;
            failures  = 0;
        endfunction

        function int unsigned pending();
            return result_q.size();
        endfunction

        // insert before idx, idx clamped to the tail; caller checks room
        function void insert_code(int sel, int unsigned idx, logic signed [CODE_W-1:0] code);
            if (idx > counts[sel]) begin
                idx = counts[sel];
            end
            for (int i = counts[sel]; i > idx; i--) begin
                lists[sel][i] = lists[sel][i-1];
            end
            lists[sel][idx] = code;
            counts[sel]++;
        endfunction

        // take out the entry at idx, idx clamped to the last; caller checks non-empty
        function logic signed [CODE_W-1:0] take_code(int sel, int unsigned idx);
            logic signed [CODE_W-1:0] code;
            if (idx >= counts[sel]) begin
                idx = counts[sel] - 1;
            end
            code = lists[sel][idx];
            for (int i = idx; i + 1 < counts[sel]; i++) begin
                lists[sel][i] = lists[sel][i+1];
            end
            counts[sel]--;
            return code;
        endfunction

        function void note_command(in_word_t w);
            out_word_t   res;
            int          sel;
            int unsigned idx;
            res         = '0;
            res.status  = ST_OK;
            sel         = (w.list_select == LIST_B) ? 1 : 0;
            idx         = (w.position <= 1) ? 0 : w.position - 1;
            case (w.cmd)
                CMD_INSERT: begin
                    if (counts[sel] >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        insert_code(sel, idx, w.item_code);
                    end
                end
                CMD_REMOVE: begin
                    if (counts[sel] == 0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.result_code = take_code(sel, idx);
                    end
                end
                CMD_MOVE: begin
                    // empty a wins over full b
                    if (counts[0] == 0) begin
                        res.status = ST_EMPTY;
                    end else if (counts[1] >= LIST_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        res.result_code = take_code(0, idx);
                        insert_code(1, counts[1], res.result_code);
                    end
                end
                default: ;
            endcase
            res.count_a = COUNT_W'(counts[0]);
            res.count_b = COUNT_W'(counts[1]);
            result_q.push_back(res);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (result_q.size() == 0) begin
                $error("result word with no command pending: %h", got);
                failures++;
                return;
            end
            want = result_q.pop_front();
            if (got.result_code !== want.result_code) begin
                $error("result_code expected %0d got %0d", want.result_code, got.result_code);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status expected %0d got %0d", want.status, got.status);
                failures++;
            end
            if (got.count_a !== want.count_a) begin
                $error("count_a expected %0d got %0d", want.count_a, got.count_a);
                failures++;
            end
            if (got.count_b !== want.count_b) begin
                $error("count_b expected %0d got %0d", want.count_b, got.count_b);
                failures++;
            end
        endfunction

    endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import dpol_pkg::*;
    import dpol_tb_pkg::*;

    localparam int RANDOM_WORDS = 1850;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASE_LEN    = 60;

    // random traffic mixes: grow both lists, shrink both, balanced, and a to b transfer
    typedef enum logic [1:0] {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED,
        MIX_TRANSFER
    } mix_phase_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    list_scoreboard sb;
    int unsigned    cycle_count;
    bit             send_calm;
    bit             recv_calm;

    dual_positional_ordered_list_unit #(
        .LIST_DEPTH(LIST_DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 4 ns clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic in_word_t cmd_word(logic [CMD_W-1:0] cmd, logic sel,
                                          logic [POS_W-1:0] pos, logic [CODE_W-1:0] code);
        in_word_t w;
        w.cmd         = cmd;
        w.list_select = sel;
        w.position    = pos;
        w.item_code   = code;
        return w;
    endfunction

    function automatic in_word_t random_word(mix_phase_t ph);
        in_word_t w;
        int       r;
        int       p_ins;
        int       p_rem;
        int       p_sel_b;
        r = $urandom_range(0, 99);
        // weights per mix: insert share, remove share, chance that a target is list b
        case (ph)
            MIX_FILL:     begin p_ins = 75; p_rem = 10; p_sel_b = 50; end
            MIX_DRAIN:    begin p_ins = 10; p_rem = 65; p_sel_b = 65; end
            MIX_TRANSFER: begin p_ins = 20; p_rem = 30; p_sel_b = 0;  end
            default:      begin p_ins = 45; p_rem = 35; p_sel_b = 50; end
        endcase
        if (r < p_ins) begin
            w.cmd = CMD_INSERT;
        end else if (r < p_ins + p_rem) begin
            w.cmd = CMD_REMOVE;
        end else if (r < 98) begin
            w.cmd = CMD_MOVE;
        end else begin
            w.cmd = CMD_UNUSED;
        end
        if (w.cmd == CMD_MOVE || w.cmd == CMD_UNUSED) begin
            // list_select means nothing here, so let it wander
            w.list_select = 1'($urandom_range(0, 1));
        end else begin
            w.list_select = ($urandom_range(0, 99) < p_sel_b) ? LIST_B : LIST_A;
        end
        // mostly positions around the list size, some anywhere in range
        if ($urandom_range(0, 9) < 7) begin
            w.position = POS_W'($urandom_range(0, LIST_DEPTH + 2));
        end else begin
            w.position = POS_W'($urandom_range(0, 255));
        end
        w.item_code = $urandom();
        return w;
    endfunction

    // present one command word at a falling edge, hold it until taken
    task automatic send_word(in_word_t w);
        int gap;
        gap = send_calm ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        sb.note_command(w);
    endtask

    // result side back pressure, with quiet stretches of ready held high
    initial begin
        int stall;
        int tick;
        stall = 0;
        tick  = 0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            tick++;
            if (tick % 400 == 0) begin
                recv_calm = ($urandom_range(0, 3) == 0);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (!recv_calm && $urandom_range(0, 99) < 25) begin
                    stall = pick_gap();
                end
            end
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
    end

    // run watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        mix_phase_t phase;
        sb          = new();
        send_calm   = 1'b0;
        recv_calm   = 1'b0;
        phase       = MIX_BALANCED;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty sources and the unused command
        send_word(cmd_word(CMD_REMOVE, LIST_A, 8'd1, 32'h0000_0000));
        send_word(cmd_word(CMD_REMOVE, LIST_B, 8'd255, 32'hffff_ffff));
        send_word(cmd_word(CMD_MOVE, LIST_B, 8'd0, 32'h1234_5678));
        send_word(cmd_word(CMD_UNUSED, LIST_B, 8'd255, 32'hffff_ffff));
        // inserts at front, before front, past the end and in the middle
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd0, 32'h7fff_ffff));
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd1, 32'h8000_0000));
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd255, 32'hffff_ffff));
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd2, 32'h0000_0000));
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd3, 32'h0000_04d2));
        send_word(cmd_word(CMD_INSERT, LIST_A, 8'd6, 32'h0000_0001));
        send_word(cmd_word(CMD_INSERT, LIST_B, 8'd200, 32'h5a5a_5a5a));
        send_word(cmd_word(CMD_UNUSED, LIST_A, 8'd2, 32'h0000_0000));
        // single entry removal empties b
        send_word(cmd_word(CMD_REMOVE, LIST_B, 8'd1, 32'ha5a5_a5a5));
        // moves from the tail, front and middle of a
        send_word(cmd_word(CMD_MOVE, LIST_A, 8'd255, 32'h0000_0000));
        send_word(cmd_word(CMD_MOVE, LIST_B, 8'd0, 32'hffff_ffff));
        send_word(cmd_word(CMD_MOVE, LIST_A, 8'd2, 32'h0000_0000));
        // remove past the end, at the front, then the last entry
        send_word(cmd_word(CMD_REMOVE, LIST_A, 8'd255, 32'hdead_beef));
        send_word(cmd_word(CMD_REMOVE, LIST_A, 8'd0, 32'h0000_0000));
        send_word(cmd_word(CMD_REMOVE, LIST_A, 8'd9, 32'h0000_0000));
        send_word(cmd_word(CMD_MOVE, LIST_A, 8'd1, 32'h0000_0000));
        send_word(cmd_word(CMD_REMOVE, LIST_B, 8'd2, 32'h0000_0000));
        send_word(cmd_word(CMD_REMOVE, LIST_B, 8'd128, 32'h0000_0000));

        // random traffic in mixes that push the lists to full and to empty
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % PHASE_LEN == 0) begin
                phase = mix_phase_t'($urandom_range(0, 3));
            end
            if (n % 150 == 0) begin
                send_calm = ($urandom_range(0, 3) == 0);
            end
            send_word(random_word(phase));
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (sb.pending() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(posedge aclk);
        if (sb.failures == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
